// File: src/assert_macros.svh
// Shared assertion forms, clocked on clk and quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EFH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EFH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/efh_pkg.sv
package efh_pkg;

	localparam int W = 32;
	localparam int F = 16;
	localparam int DW = 2 * W;
	localparam int CFG_IDX_W = 3;

	localparam int DIV_LAT = W + 2;
	localparam int SQRT_LAT = W;
	localparam int LANE_LAT = 2 * (DIV_LAT + 2);
	localparam int MERGE_LAT = SQRT_LAT + DIV_LAT + 6;
	localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

	typedef logic signed [W-1:0] word_t;
	typedef word_t [2:0] vec3_t;
	typedef vec3_t [2:0] cols_t;

	localparam word_t WORD_MAX = {1'b0, {(W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X  = 3'd0,
		REG_FOCAL_Y  = 3'd1,
		REG_SKEW     = 3'd2,
		REG_CENTER_U = 3'd3,
		REG_CENTER_V = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [W-1:0]         data;
	} cfg_wr_t;

	typedef struct packed {
		logic [W-2:0] focal_x;
		logic [W-2:0] focal_y;
		word_t        skew;
		word_t        center_u;
		word_t        center_v;
	} kparams_t;

	typedef struct packed {
		word_t h00;
		word_t h01;
		word_t h02;
		word_t h10;
		word_t h11;
		word_t h12;
		word_t h20;
		word_t h21;
		word_t h22;
	} homog_t;

	typedef struct packed {
		word_t r00;
		word_t r01;
		word_t r02;
		word_t r10;
		word_t r11;
		word_t r12;
		word_t r20;
		word_t r21;
		word_t r22;
		word_t t_x;
		word_t t_y;
		word_t t_z;
	} pose_t;

endpackage

// File: src/efh_stream_if.sv
interface efh_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: src/efh_div.sv
module efh_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 31
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output efh_pkg::word_t          q
);
	import efh_pkg::*;

	localparam int HI_W = NUM_W - W;

	logic [NUM_W-1:0]      mag;
	logic [HI_W+DEN_W-1:0] hi_ext;
	logic                  ovf;

	logic [DEN_W-1:0] rem_s  [0:W];
	logic [DEN_W-1:0] den_s  [0:W];
	logic [W-1:0]     bits_s [0:W];
	logic             neg_s  [0:W];
	logic             ovf_s  [0:W];
	word_t            q_s;

	assign mag    = num[NUM_W-1] ? (~num + 1'b1) : num;
	assign hi_ext = {{DEN_W{1'b0}}, mag[NUM_W-1:W]};
	// quotient needs more than W bits: saturate regardless of the low bits
	assign ovf    = hi_ext >= {{HI_W{1'b0}}, den};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= hi_ext[DEN_W-1:0];
			den_s[0]  <= den;
			bits_s[0] <= mag[W-1:0];
			neg_s[0]  <= num[NUM_W-1];
			ovf_s[0]  <= ovf;
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		assign trial = {rem_s[k], bits_s[k][W-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				den_s[k+1]  <= den_s[k];
				bits_s[k+1] <= {bits_s[k][W-2:0], ge};
				neg_s[k+1]  <= neg_s[k];
				ovf_s[k+1]  <= ovf_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_s[W]) begin
				q_s <= (ovf_s[W] || bits_s[W][W-1]) ? WORD_MAX : word_t'(bits_s[W]);
			end else if (ovf_s[W] || (bits_s[W][W-1] && (|bits_s[W][W-2:0]))) begin
				q_s <= WORD_MIN;
			end else begin
				q_s <= word_t'(~bits_s[W] + 1'b1);
			end
		end
	end

	assign q = q_s;

endmodule

// File: src/efh_isqrt.sv
module efh_isqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [efh_pkg::DW-1:0]    s,
	output logic [efh_pkg::W-1:0]     root
);
	import efh_pkg::*;

	logic [W-1:0]  rem_s  [1:W];
	logic [W-1:0]  root_s [1:W];
	logic [DW-1:0] src_s  [1:W];

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [W-1:0]  rem_in;
		logic [W-1:0]  root_in;
		logic [DW-1:0] src_in;
		logic [W+1:0]  t;
		logic [W+1:0]  trial;
		logic [W+1:0]  diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign src_in  = s;
		end else begin : g_rest
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
			assign src_in  = src_s[k];
		end

		// bring down the next two radicand bits and try a one in the root
		assign t     = {rem_in, src_in[DW-1:DW-2]};
		assign trial = {root_in, 2'b01};
		assign diff  = t - trial;
		assign ge    = t >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[W-1:0] : t[W-1:0];
				root_s[k+1] <= {root_in[W-2:0], ge};
				src_s[k+1]  <= {src_in[DW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[W];

endmodule

// File: src/efh_lane.sv
module efh_lane (
	input  logic              clk,
	input  logic              en,
	input  efh_pkg::kparams_t kp,
	input  efh_pkg::word_t    a,
	input  efh_pkg::word_t    b,
	input  efh_pkg::word_t    c,
	output efh_pkg::vec3_t    q
);
	import efh_pkg::*;

	localparam int D1 = DIV_LAT + 2;

	logic signed [DW-1:0] pb_s1, pcv_s1;
	logic signed [DW-1:0] n1_s2;
	logic signed [DW-1:0] pa_s3, ps_s3, pu_s3;
	logic signed [DW-1:0] n0_s4;
	logic [DW+1:0]        sum0;
	word_t                q1, q0;

	word_t a_d  [0:D1-1];
	word_t c_d  [0:2*D1-1];
	word_t q1_d [0:D1-1];

	always_ff @(posedge clk) begin
		if (en) begin
			a_d[0]  <= a;
			c_d[0]  <= c;
			q1_d[0] <= q1;
			for (int k = 1; k < D1; k++) begin
				a_d[k]  <= a_d[k-1];
				q1_d[k] <= q1_d[k-1];
			end
			for (int k = 1; k < 2 * D1; k++) begin
				c_d[k] <= c_d[k-1];
			end
		end
	end

	// second row of inv(K): q1 = (b - center_v * c) / focal_y
	always_ff @(posedge clk) begin
		if (en) begin
			pb_s1  <= {{W{b[W-1]}}, b} <<< F;
			pcv_s1 <= kp.center_v * c;
			n1_s2  <= pb_s1 - pcv_s1;
		end
	end

	efh_div #(.NUM_W(DW), .DEN_W(W-1)) u_div_y (
		.clk (clk),
		.en  (en),
		.num (n1_s2),
		.den (kp.focal_y),
		.q   (q1)
	);

	// first row: q0 = (a - skew * q1 - center_u * c) / focal_x
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s3 <= {{W{a_d[D1-1][W-1]}}, a_d[D1-1]} <<< F;
			ps_s3 <= kp.skew * q1;
			pu_s3 <= kp.center_u * c_d[D1-1];
		end
	end

	assign sum0 = {{2{pa_s3[DW-1]}}, pa_s3} - {{2{ps_s3[DW-1]}}, ps_s3}
		- {{2{pu_s3[DW-1]}}, pu_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum0[DW+1:DW-1] == 3'b000 || sum0[DW+1:DW-1] == 3'b111) begin
				n0_s4 <= sum0[DW-1:0];
			end else if (sum0[DW+1]) begin
				n0_s4 <= {1'b1, {(DW-1){1'b0}}};
			end else begin
				n0_s4 <= {1'b0, {(DW-1){1'b1}}};
			end
		end
	end

	efh_div #(.NUM_W(DW), .DEN_W(W-1)) u_div_x (
		.clk (clk),
		.en  (en),
		.num (n0_s4),
		.den (kp.focal_x),
		.q   (q0)
	);

	assign q[0] = q0;
	assign q[1] = q1_d[D1-1];
	assign q[2] = c_d[2*D1-1];

endmodule

// File: src/efh_merge.sv
module efh_merge (
	input  logic           clk,
	input  logic           en,
	input  efh_pkg::vec3_t cols [3],
	output efh_pkg::pose_t pose
);
	import efh_pkg::*;

	localparam int QD = SQRT_LAT + 2;

	cols_t                cin;
	logic [DW-1:0]        sq_s1 [3];
	logic [DW-1:0]        sum_s2;
	logic [W-1:0]         root;
	cols_t                qd_s [0:QD-1];
	logic                 zd_s [0:DIV_LAT-1];
	word_t                sc [3][3];
	cols_t                msk_s, c1_s, c2_s, c3_s;
	logic signed [DW-1:0] pxy_s1 [3];
	logic signed [DW-1:0] pzw_s1 [3];
	logic signed [DW-1:0] d_s2 [3];
	word_t                cr_s3 [3];

	assign cin = {cols[2], cols[1], cols[0]};

	// norm of the first column
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= cols[0][i] * cols[0][i];
			end
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	efh_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.s    (sum_s2),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			qd_s[0] <= cin;
			for (int k = 1; k < QD; k++) begin
				qd_s[k] <= qd_s[k-1];
			end
			zd_s[0] <= (root == '0);
			for (int k = 1; k < DIV_LAT; k++) begin
				zd_s[k] <= zd_s[k-1];
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_col
		for (genvar i = 0; i < 3; i++) begin : g_row
			efh_div #(.NUM_W(W+F), .DEN_W(W)) u_div (
				.clk (clk),
				.en  (en),
				.num ({qd_s[QD-1][k][i], {F{1'b0}}}),
				.den (root),
				.q   (sc[k][i])
			);
		end
	end

	// zero norm clears every output, the cross products follow from zeros
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					msk_s[k][i] <= zd_s[DIV_LAT-1] ? '0 : sc[k][i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxy_s1[0] <= msk_s[0][1] * msk_s[1][2];
			pzw_s1[0] <= msk_s[0][2] * msk_s[1][1];
			pxy_s1[1] <= msk_s[0][2] * msk_s[1][0];
			pzw_s1[1] <= msk_s[0][0] * msk_s[1][2];
			pxy_s1[2] <= msk_s[0][0] * msk_s[1][1];
			pzw_s1[2] <= msk_s[0][1] * msk_s[1][0];
			c1_s <= msk_s;
			c2_s <= c1_s;
			c3_s <= c2_s;
			for (int i = 0; i < 3; i++) begin
				d_s2[i] <= pxy_s1[i] - pzw_s1[i];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_cross
		logic signed [DW-1:0] adj;
		logic signed [DW-1:0] sh;

		// round toward zero before the arithmetic shift
		assign adj = d_s2[i] + (d_s2[i][DW-1] ? DW'((1 << F) - 1) : DW'(0));
		assign sh  = adj >>> F;

		always_ff @(posedge clk) begin
			if (en) begin
				if ((&sh[DW-1:W-1]) || !(|sh[DW-1:W-1])) begin
					cr_s3[i] <= sh[W-1:0];
				end else begin
					cr_s3[i] <= sh[DW-1] ? WORD_MIN : WORD_MAX;
				end
			end
		end
	end

	assign pose.r00 = c3_s[0][0];
	assign pose.r10 = c3_s[0][1];
	assign pose.r20 = c3_s[0][2];
	assign pose.r01 = c3_s[1][0];
	assign pose.r11 = c3_s[1][1];
	assign pose.r21 = c3_s[1][2];
	assign pose.r02 = cr_s3[0];
	assign pose.r12 = cr_s3[1];
	assign pose.r22 = cr_s3[2];
	assign pose.t_x = c3_s[2][0];
	assign pose.t_y = c3_s[2][1];
	assign pose.t_z = c3_s[2][2];

endmodule

// File: src/extrinsics_from_homography_core.sv
// A homography runs through the three lanes and the merge, then the output register, to pose valid.
// Throughput: one homography per cycle while hom.ready is high; set by the fully pipelined dividers
// (one quotient bit per stage) and the square root (one root bit per stage).
// A stalled pose fills one skid entry; only then does hom.ready drop.
// Reset: arst_n clears valid state and loads focal lengths 1.0, others 0.
`include "assert_macros.svh"

module extrinsics_from_homography_core (
	input  logic        clk,
	input  logic        arst_n,
	efh_stream_if.sink   cfg,
	efh_stream_if.sink   hom,
	efh_stream_if.source pose
);
	import efh_pkg::*;

	logic [W-2:0]      focal_x_q, focal_y_q;
	word_t             skew_q, center_u_q, center_v_q;
	kparams_t          kp;
	homog_t            h;
	vec3_t             lane_q [3];
	pose_t             tail;
	logic              en;
	logic              tail_vld;
	logic [PIPE_LAT-1:0] vld_s;
	pose_t             out_q, skid_q;
	logic              out_vld_q, skid_vld_q;
	logic              out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= (W-1)'(1 << F);
			focal_y_q  <= (W-1)'(1 << F);
			skew_q     <= '0;
			center_u_q <= '0;
			center_v_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				REG_FOCAL_X:  focal_x_q  <= cfg.payload.data[W-2:0];
				REG_FOCAL_Y:  focal_y_q  <= cfg.payload.data[W-2:0];
				REG_SKEW:     skew_q     <= cfg.payload.data;
				REG_CENTER_U: center_u_q <= cfg.payload.data;
				REG_CENTER_V: center_v_q <= cfg.payload.data;
				default: ;
			endcase
		end
	end

	// a zero focal length divides as the smallest raw value
	assign kp.focal_x  = (focal_x_q == '0) ? (W-1)'(1) : focal_x_q;
	assign kp.focal_y  = (focal_y_q == '0) ? (W-1)'(1) : focal_y_q;
	assign kp.skew     = skew_q;
	assign kp.center_u = center_u_q;
	assign kp.center_v = center_v_q;

	assign en        = !skid_vld_q;
	assign hom.ready = en;
	assign h         = hom.payload;

	efh_lane u_lane0 (
		.clk (clk), .en (en), .kp (kp),
		.a (h.h00), .b (h.h10), .c (h.h20), .q (lane_q[0])
	);

	efh_lane u_lane1 (
		.clk (clk), .en (en), .kp (kp),
		.a (h.h01), .b (h.h11), .c (h.h21), .q (lane_q[1])
	);

	efh_lane u_lane2 (
		.clk (clk), .en (en), .kp (kp),
		.a (h.h02), .b (h.h12), .c (h.h22), .q (lane_q[2])
	);

	efh_merge u_merge (
		.clk  (clk),
		.en   (en),
		.cols (lane_q),
		.pose (tail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], hom.valid};
		end
	end

	assign tail_vld = vld_s[PIPE_LAT-1];
	assign out_free = !out_vld_q || pose.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pose.ready) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (tail_vld) begin
			// park the result in the skid entry when the output is held
			if (out_free) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (pose.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pose.ready) begin
				out_q <= skid_q;
			end
		end else if (tail_vld) begin
			if (out_free) begin
				out_q <= tail;
			end else begin
				skid_q <= tail;
			end
		end
	end

	assign pose.valid   = out_vld_q;
	assign pose.payload = out_q;

	`EFH_ASSERT_SAME(a_skid_behind_out, skid_vld_q, out_vld_q,
		"skid entry holds a pose while the output register is empty")
	`EFH_ASSERT_NEXT(a_skid_drains, skid_vld_q && pose.ready, !skid_vld_q && out_vld_q,
		"skid entry did not move to the output after a transfer")
	`EFH_ASSERT_NEXT(a_tail_kept, en && tail_vld && out_vld_q && !pose.ready, skid_vld_q,
		"pipeline result dropped while the output was held")

endmodule

// File: tb/tb_extrinsics_from_homography_core.sv
module tb_extrinsics_from_homography_core;
	import efh_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 500;
	localparam int ITEMS_PER_PHASE = 142;

	logic clk;
	logic arst_n;

	efh_stream_if #(.payload_t(cfg_wr_t)) cfg_if ();
	efh_stream_if #(.payload_t(homog_t)) hom_if ();
	efh_stream_if #(.payload_t(pose_t)) pose_if ();

	extrinsics_from_homography_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if.sink),
		.hom(hom_if.sink),
		.pose(pose_if.source)
	);

	// intrinsics as the block should hold them
	longint k_fx, k_fy, k_skew, k_cu, k_cv;

	homog_t hom_pending[$];
	pose_t  pose_expected[$];

	int src_idle_pct;
	int snk_idle_pct;
	logic hold_arm;
	logic hold_used;
	int hold_left;
	int failures = 0;
	int quiet_cycles = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint sat_word(longint x);
		if (x > longint'(WORD_MAX)) return longint'(WORD_MAX);
		if (x < longint'(WORD_MIN)) return longint'(WORD_MIN);
		return x;
	endfunction

	function automatic longint sat_sum(longint a, longint b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return longint'(s[63:0]);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// back substitution through the upper-triangular intrinsic matrix
	function automatic void undo_intrinsics(longint a, longint b, longint c,
		output longint q0, output longint q1);
		longint fx, fy, n0, n1;
		fx = (k_fx == 0) ? 1 : k_fx;
		fy = (k_fy == 0) ? 1 : k_fy;
		n1 = sat_sum(b * 65536, -(k_cv * c));
		q1 = sat_word(n1 / fy);
		n0 = sat_sum(sat_sum(a * 65536, -(k_skew * q1)), -(k_cu * c));
		q0 = sat_word(n0 / fx);
	endfunction

	function automatic longint cross_entry(longint x, longint y, longint z, longint w);
		longint d;
		d = x * y - z * w;
		return sat_word(d / 65536);
	endfunction

	function automatic pose_t pose_of(homog_t h);
		longint a0, a1, a2, b0, b1, b2, c0, c1, c2;
		longint unsigned sq;
		longint n;
		longint r00, r10, r20, r01, r11, r21;
		pose_t p;
		undo_intrinsics(longint'(h.h00), longint'(h.h10), longint'(h.h20), a0, a1);
		a2 = longint'(h.h20);
		undo_intrinsics(longint'(h.h01), longint'(h.h11), longint'(h.h21), b0, b1);
		b2 = longint'(h.h21);
		undo_intrinsics(longint'(h.h02), longint'(h.h12), longint'(h.h22), c0, c1);
		c2 = longint'(h.h22);
		sq = longint'(a0 * a0) + longint'(a1 * a1) + longint'(a2 * a2);
		n = longint'(root_floor(sq));
		p = '0;
		if (n == 0) return p;
		r00 = sat_word((a0 * 65536) / n);
		r10 = sat_word((a1 * 65536) / n);
		r20 = sat_word((a2 * 65536) / n);
		r01 = sat_word((b0 * 65536) / n);
		r11 = sat_word((b1 * 65536) / n);
		r21 = sat_word((b2 * 65536) / n);
		p.r00 = word_t'(r00);
		p.r10 = word_t'(r10);
		p.r20 = word_t'(r20);
		p.r01 = word_t'(r01);
		p.r11 = word_t'(r11);
		p.r21 = word_t'(r21);
		p.t_x = word_t'(sat_word((c0 * 65536) / n));
		p.t_y = word_t'(sat_word((c1 * 65536) / n));
		p.t_z = word_t'(sat_word((c2 * 65536) / n));
		p.r02 = word_t'(cross_entry(r10, r21, r20, r11));
		p.r12 = word_t'(cross_entry(r20, r01, r00, r21));
		p.r22 = word_t'(cross_entry(r00, r11, r10, r01));
		return p;
	endfunction

	task automatic report_mismatch(string what, word_t got, word_t want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		failures++;
	endtask

	// homography source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hom_if.valid <= 1'b0;
			hom_if.payload <= '0;
		end else begin
			if (hom_if.valid && hom_if.ready)
				pose_expected = {pose_expected, pose_of(hom_if.payload)};
			if (!hom_if.valid || hom_if.ready) begin
				if (hom_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					hom_if.valid <= 1'b1;
					hom_if.payload <= hom_pending.pop_front();
				end else begin
					hom_if.valid <= 1'b0;
				end
			end
		end
	end

	// pose sink and checker
	always @(posedge clk or negedge arst_n) begin
		pose_t want;
		pose_t got;
		if (!arst_n) begin
			pose_if.ready <= 1'b0;
			hold_left <= 0;
			hold_used <= 1'b0;
		end else begin
			if (pose_if.valid && pose_if.ready) begin
				got = pose_if.payload;
				if (pose_expected.size() == 0) begin
					$display("unexpected pose transfer");
					failures++;
				end else begin
					want = pose_expected.pop_front();
					if (got.r00 !== want.r00) report_mismatch("r00", got.r00, want.r00);
					if (got.r01 !== want.r01) report_mismatch("r01", got.r01, want.r01);
					if (got.r02 !== want.r02) report_mismatch("r02", got.r02, want.r02);
					if (got.r10 !== want.r10) report_mismatch("r10", got.r10, want.r10);
					if (got.r11 !== want.r11) report_mismatch("r11", got.r11, want.r11);
					if (got.r12 !== want.r12) report_mismatch("r12", got.r12, want.r12);
					if (got.r20 !== want.r20) report_mismatch("r20", got.r20, want.r20);
					if (got.r21 !== want.r21) report_mismatch("r21", got.r21, want.r21);
					if (got.r22 !== want.r22) report_mismatch("r22", got.r22, want.r22);
					if (got.t_x !== want.t_x) report_mismatch("t_x", got.t_x, want.t_x);
					if (got.t_y !== want.t_y) report_mismatch("t_y", got.t_y, want.t_y);
					if (got.t_z !== want.t_z) report_mismatch("t_z", got.t_z, want.t_z);
				end
			end
			if (hold_arm && !hold_used) begin
				hold_used <= 1'b1;
				hold_left <= LONG_HOLD;
				pose_if.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				pose_if.ready <= 1'b0;
			end else begin
				pose_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((hom_if.valid && hom_if.ready) || (pose_if.valid && pose_if.ready)
			|| (cfg_if.valid && cfg_if.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.payload <= '{index: idx, data: data};
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_FOCAL_X:  k_fx = longint'({1'b0, data[W-2:0]});
			REG_FOCAL_Y:  k_fy = longint'({1'b0, data[W-2:0]});
			REG_SKEW:     k_skew = longint'(signed'(data));
			REG_CENTER_U: k_cu = longint'(signed'(data));
			REG_CENTER_V: k_cv = longint'(signed'(data));
			default: ;
		endcase
	endtask

	task automatic load_intrinsics(logic [W-1:0] fx, logic [W-1:0] fy, logic [W-1:0] sk,
		logic [W-1:0] cu, logic [W-1:0] cv);
		cfg_write(REG_FOCAL_X, fx);
		cfg_write(REG_FOCAL_Y, fy);
		cfg_write(REG_SKEW, sk);
		cfg_write(REG_CENTER_U, cu);
		cfg_write(REG_CENTER_V, cv);
		// unknown indexes must be ignored
		cfg_write(3'd5 + CFG_IDX_W'($urandom_range(2)), $urandom);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		do @(posedge clk);
		while (hom_pending.size() > 0 || hom_if.valid || pose_expected.size() > 0);
	endtask

	task automatic add_hom(homog_t h);
		hom_pending = {hom_pending, h};
	endtask

	function automatic word_t rand_entry();
		int sel;
		sel = $urandom_range(9);
		if (sel < 3) return word_t'($urandom);
		if (sel == 3) return ($urandom_range(1)) ? WORD_MAX : WORD_MIN;
		if (sel == 4) return '0;
		// moderate magnitudes like real plane homographies
		return word_t'(signed'($urandom) >>> $urandom_range(30, 6));
	endfunction

	function automatic homog_t rand_homography();
		homog_t h;
		h.h00 = rand_entry();
		h.h01 = rand_entry();
		h.h02 = rand_entry();
		h.h10 = rand_entry();
		h.h11 = rand_entry();
		h.h12 = rand_entry();
		h.h20 = rand_entry();
		h.h21 = rand_entry();
		h.h22 = rand_entry();
		return h;
	endfunction

	task automatic queue_random(int count);
		repeat (count) add_hom(rand_homography());
	endtask

	task automatic queue_directed;
		homog_t h;
		h = '0;
		add_hom(h);
		h = '{default: WORD_MAX};
		add_hom(h);
		h = '{default: WORD_MIN};
		add_hom(h);
		h = '0;
		h.h00 = 32'sh0001_0000;
		h.h11 = 32'sh0001_0000;
		h.h22 = 32'sh0001_0000;
		add_hom(h);
		h.h20 = 32'sh0000_0001;
		h.h00 = '0;
		add_hom(h);
		h = '{default: WORD_MAX};
		h.h10 = WORD_MIN;
		h.h21 = WORD_MIN;
		add_hom(h);
		h = '{default: WORD_MIN};
		h.h00 = WORD_MAX;
		h.h11 = WORD_MAX;
		add_hom(h);
		h = '0;
		h.h00 = 32'sh0000_0001;
		h.h01 = WORD_MAX;
		h.h12 = WORD_MIN;
		add_hom(h);
		h = '0;
		h.h10 = 32'sh0000_0100;
		h.h01 = WORD_MAX;
		h.h11 = WORD_MAX;
		h.h21 = WORD_MIN;
		h.h02 = WORD_MIN;
		add_hom(h);
		queue_random(12);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.payload = '0;
		src_idle_pct = 34;
		snk_idle_pct = 79;
		hold_arm = 1'b0;
		k_fx = 65536;
		k_fy = 65536;
		k_skew = 0;
		k_cu = 0;
		k_cv = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset intrinsics
		queue_directed();
		queue_random(ITEMS_PER_PHASE - 21);
		drain();

		src_idle_pct = 79;
		snk_idle_pct = 34;
		load_intrinsics(32'd800 << 16, 32'd780 << 16, 32'h0000_1000, 32'd320 << 16,
			32'd240 << 16);
		queue_directed();
		queue_random(ITEMS_PER_PHASE - 21);
		drain();

		// no idling; one long receiver stall to back the pipeline up
		src_idle_pct = 0;
		snk_idle_pct = 0;
		load_intrinsics(32'h7FFF_FFFF, 32'd1, WORD_MIN, WORD_MAX, WORD_MIN);
		queue_random(2 * ITEMS_PER_PHASE);
		repeat (20) @(posedge clk);
		hold_arm <= 1'b1;
		drain();

		src_idle_pct = 34;
		snk_idle_pct = 79;
		// focal lengths of zero act as the smallest value
		load_intrinsics(32'h8000_0000, 32'h0000_0000, WORD_MAX, WORD_MIN, WORD_MAX);
		queue_directed();
		queue_random(ITEMS_PER_PHASE - 21);
		drain();

		src_idle_pct = 79;
		snk_idle_pct = 34;
		load_intrinsics($urandom, $urandom, $urandom, $urandom, $urandom);
		queue_random(ITEMS_PER_PHASE / 2);
		drain();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		load_intrinsics(32'd1, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
		queue_random(ITEMS_PER_PHASE / 2);
		drain();

		repeat (4 * W + 40) @(posedge clk);
		if (pose_expected.size() > 0)
			$display("%0d poses never arrived", pose_expected.size());
		if (failures == 0 && pose_expected.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
